@@ rtl/core/pnu_pkg.sv @@
`timescale 1ns / 1ps
package pnu_pkg;

  // default field widths
  localparam int SAMPLE_WIDTH_DEF = 24;
  localparam int OUT_WIDTH_DEF    = 16;

  // epsilon register
  localparam int EPS_WIDTH = 24;
  localparam logic [EPS_WIDTH-1:0] EPS_RESET = EPS_WIDTH'(1);

  // stream word width for a given payload width, rounded up to bytes
  function automatic int byte_round(input int bits);
    return ((bits + 7) / 8) * 8;
  endfunction

endpackage

@@ rtl/core/phasor_normalizer_unit.sv @@
`timescale 1ns / 1ps
// phasor normaliser: scales one complex bin to unit length
//
// in_*  : stream of bins, in_tdata = real_in, imag_in (signed, lowest bits first)
// out_* : stream of results, out_tdata = real_out, imag_out (signed q1.15 by default)
// cfg_* : epsilon write channel, always ready; user writes only while idle, unchecked
//
// one bin enters per cycle while in_tready is high, and one result leaves per
// cycle when the receiver takes it. the pipeline is made of the bit-per-stage
// square root (SAMPLE_WIDTH stages) and the bit-per-stage restoring dividers
// (OUT_WIDTH stages) plus abs, square, sum, epsilon add and saturation stages.
//
// every stage has its own valid bit and moves when the next stage is empty or
// moving, so bubbles close up and a stall on out_tready holds all words without
// loss; in_tready falls only once the whole pipeline is full.
//
// synchronous reset clears all valid bits and sets epsilon to 1.
module phasor_normalizer_unit #(
  parameter int SAMPLE_WIDTH = pnu_pkg::SAMPLE_WIDTH_DEF,
  parameter int OUT_WIDTH    = pnu_pkg::OUT_WIDTH_DEF,
  localparam int IN_TW  = pnu_pkg::byte_round(2 * SAMPLE_WIDTH),
  localparam int OUT_TW = pnu_pkg::byte_round(2 * OUT_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pnu_pkg::EPS_WIDTH-1:0] cfg_data,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [IN_TW-1:0]              in_tdata,   // real_in, imag_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_TW-1:0]             out_tdata   // real_out, imag_out
);
  import pnu_pkg::*;

  localparam int SW  = SAMPLE_WIDTH;
  localparam int OW  = OUT_WIDTH;
  localparam int R   = SW;
  localparam int SQW = 2 * SW;
  localparam int RW  = R + 2;
  localparam int MW  = ((SW > EPS_WIDTH) ? SW : EPS_WIDTH) + 1;
  localparam int NS  = R + OW + 5;
  localparam int ST_SQ  = 3;
  localparam int ST_EPS = R + 3;
  localparam int ST_DIV = R + 4;
  localparam int ST_OUT = R + OW + 4;

  // epsilon register
  logic [EPS_WIDTH-1:0] eps_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_RESET;
    end else if (cfg_valid) begin
      eps_r <= cfg_data;
    end
  end

  // stage enables, ready travels back from the output
  logic [NS-1:0] v_r;
  logic [NS-1:0] en;
  always_comb begin
    en[NS-1] = !v_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end
  assign in_tready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v_r[i] <= (i == 0) ? in_tvalid : v_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
  end

  // magnitudes and signs travel along every stage
  logic [SW-1:0] ra_r [NS];
  logic [SW-1:0] ia_r [NS];
  logic          rn_r [NS];
  logic          in_r [NS];

  // stage 0: split into sign and magnitude
  logic [SW-1:0] re_in, im_in;
  assign re_in = in_tdata[SW-1:0];
  assign im_in = in_tdata[2*SW-1:SW];
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rn_r[0] <= re_in[SW-1];
      in_r[0] <= im_in[SW-1];
      ra_r[0] <= re_in[SW-1] ? (~re_in + SW'(1)) : re_in;
      ia_r[0] <= im_in[SW-1] ? (~im_in + SW'(1)) : im_in;
    end
  end

  // carry of sign and magnitude
  genvar g;
  generate
    for (g = 1; g < NS; g++) begin : g_carry
      always_ff @(posedge clk) begin
        if (en[g]) begin
          ra_r[g] <= ra_r[g-1];
          ia_r[g] <= ia_r[g-1];
          rn_r[g] <= rn_r[g-1];
          in_r[g] <= in_r[g-1];
        end
      end
    end
  endgenerate

  // stage 1: squares
  logic [SQW-1:0] rsq_r, isq_r;
  always_ff @(posedge clk) begin
    if (en[1]) begin
      rsq_r <= SQW'(ra_r[0]) * SQW'(ra_r[0]);
      isq_r <= SQW'(ia_r[0]) * SQW'(ia_r[0]);
    end
  end

  // stage 2: sum of squares
  logic [SQW-1:0] sum_r;
  always_ff @(posedge clk) begin
    if (en[2]) begin
      sum_r <= rsq_r + isq_r;
    end
  end

  // square root, one result bit per stage
  logic [SQW-1:0] sqx_r    [R];
  logic [RW-1:0]  sqrem_r  [R];
  logic [R-1:0]   sqroot_r [R];
  generate
    for (g = 0; g < R; g++) begin : g_sqrt
      logic [SQW-1:0] x_p;
      logic [RW-1:0]  rem_p, remsh, trial;
      logic [R-1:0]   root_p;
      if (g == 0) begin : g_first
        assign x_p    = sum_r;
        assign rem_p  = '0;
        assign root_p = '0;
      end else begin : g_next
        assign x_p    = sqx_r[g-1];
        assign rem_p  = sqrem_r[g-1];
        assign root_p = sqroot_r[g-1];
      end
      assign remsh = {rem_p[RW-3:0], x_p[SQW-1:SQW-2]};
      assign trial = {root_p, 2'b01};
      always_ff @(posedge clk) begin
        if (en[ST_SQ+g]) begin
          sqx_r[g] <= {x_p[SQW-3:0], 2'b00};
          if (remsh >= trial) begin
            sqrem_r[g]  <= remsh - trial;
            sqroot_r[g] <= {root_p[R-2:0], 1'b1};
          end else begin
            sqrem_r[g]  <= remsh;
            sqroot_r[g] <= {root_p[R-2:0], 1'b0};
          end
        end
      end
    end
  endgenerate

  // epsilon add, magnitude and zero flag then ride along the divider
  logic [MW-1:0] mag_r  [OW+1];
  logic          zero_r [OW+1];
  always_ff @(posedge clk) begin
    if (en[ST_EPS]) begin
      mag_r[0]  <= MW'(sqroot_r[R-1]) + MW'(eps_r);
      zero_r[0] <= (sqroot_r[R-1] == '0) && (eps_r == '0);
    end
  end

  // restoring division of both parts, one quotient bit per stage
  logic [MW-1:0] drem_r [OW][2];
  logic [OW-1:0] dq_r   [OW][2];
  generate
    for (g = 0; g < OW; g++) begin : g_div
      logic [MW-1:0] rem_p [2];
      logic [OW-1:0] q_p   [2];
      logic          bit_p [2];
      logic [MW:0]   remsh [2];
      if (g == 0) begin : g_first
        assign rem_p[0] = MW'(ra_r[ST_EPS] >> 1);
        assign rem_p[1] = MW'(ia_r[ST_EPS] >> 1);
        assign q_p[0]   = '0;
        assign q_p[1]   = '0;
        assign bit_p[0] = ra_r[ST_EPS][0];
        assign bit_p[1] = ia_r[ST_EPS][0];
      end else begin : g_next
        assign rem_p[0] = drem_r[g-1][0];
        assign rem_p[1] = drem_r[g-1][1];
        assign q_p[0]   = dq_r[g-1][0];
        assign q_p[1]   = dq_r[g-1][1];
        assign bit_p[0] = 1'b0;
        assign bit_p[1] = 1'b0;
      end
      for (genvar p = 0; p < 2; p++) begin : g_part
        assign remsh[p] = {rem_p[p], bit_p[p]};
        always_ff @(posedge clk) begin
          if (en[ST_DIV+g]) begin
            if (remsh[p] >= {1'b0, mag_r[g]}) begin
              drem_r[g][p] <= MW'(remsh[p] - {1'b0, mag_r[g]});
              dq_r[g][p]   <= {q_p[p][OW-2:0], 1'b1};
            end else begin
              drem_r[g][p] <= remsh[p][MW-1:0];
              dq_r[g][p]   <= {q_p[p][OW-2:0], 1'b0};
            end
          end
        end
      end
      always_ff @(posedge clk) begin
        if (en[ST_DIV+g]) begin
          mag_r[g+1]  <= mag_r[g];
          zero_r[g+1] <= zero_r[g];
        end
      end
    end
  endgenerate

  // saturation and sign
  localparam logic [OW-1:0] POS_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic [OW-1:0] NEG_LIM = {1'b1, {(OW-1){1'b0}}};

  function automatic logic [OW-1:0] sat_part(input logic [OW-1:0] q, input logic neg,
                                             input logic zero);
    logic [OW-1:0] qs;
    qs = '0;
    if (zero) begin
      qs = '0;
    end else if (neg) begin
      qs = (q > NEG_LIM) ? NEG_LIM : q;
      qs = ~qs + OW'(1);
    end else begin
      qs = (q > POS_MAX) ? POS_MAX : q;
    end
    return qs;
  endfunction

  logic [OW-1:0] re_out_r, im_out_r;
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      re_out_r <= sat_part(dq_r[OW-1][0], rn_r[ST_OUT-1], zero_r[OW]);
      im_out_r <= sat_part(dq_r[OW-1][1], in_r[ST_OUT-1], zero_r[OW]);
    end
  end

  assign out_tvalid = v_r[NS-1];
  assign out_tdata  = OUT_TW'({im_out_r, re_out_r});

endmodule

@@ rtl/core/pnu_checker.sv @@
`timescale 1ns / 1ps
module pnu_checker #(
  parameter int OUT_TW = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_ready,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // an empty output stage never blocks the input
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  // a taken result frees the input
  a_take_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while result taken");

  // nothing leaves straight after reset, config always open
  a_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_tvalid && cfg_ready)
    else $error("output valid after reset");

endmodule

bind phasor_normalizer_unit pnu_checker #(.OUT_TW(OUT_TW)) u_pnu_checker (.*);
